>>> rtl/core/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit slot allocator package
// Shared constants, operation and result codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int MAX_SLOTS  = 64;
  localparam int INIT_SLOTS = 16;
  localparam int ADDR_BITS  = 32;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int ENTRY_W    = 1 + 2 * ADDR_BITS;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_FILL = 2'd3;

  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_ZERO  = 3'd1;
  localparam logic [2:0] IDX_INC   = 3'd2;
  localparam logic [2:0] IDX_DEC   = 3'd3;
  localparam logic [2:0] IDX_SEL   = 3'd4;
  localparam logic [2:0] IDX_LAST  = 3'd5;
  localparam logic [2:0] IDX_KNEXT = 3'd6;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_SHIFT = 2'd1;
  localparam logic [1:0] WR_REM   = 2'd2;
  localparam logic [1:0] WR_FILL  = 2'd3;

  localparam logic [2:0] RES_NONE   = 3'd0;
  localparam logic [2:0] RES_NOFIT  = 3'd1;
  localparam logic [2:0] RES_FULL   = 3'd2;
  localparam logic [2:0] RES_BAD    = 3'd3;
  localparam logic [2:0] RES_SEARCH = 3'd4;
  localparam logic [2:0] RES_FIND   = 3'd5;
  localparam logic [2:0] RES_FILL   = 3'd6;

  typedef struct packed {
    logic       load;
    logic       rd;
    logic       rd_prev;
    logic [2:0] idx_op;
    logic       best_clr;
    logic       eval;
    logic       save;
    logic       k_self;
    logic       k_rd;
    logic       cnt_inc;
    logic [1:0] wr;
    logic [2:0] res;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad_search;
    logic       idx_end;
    logic       sel_bad;
    logic       fill_bad;
    logic       fill_exact;
    logic       k_low;
    logic       k_hit;
    logic       k_tail;
    logic       full;
    logic       m_done;
    logic       find_hit;
    logic       out_free;
  } stat_t;

endpackage

>>> rtl/core/best_fit_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// Best-fit slot allocator unit
// Keeps the slot table of one memory pool and serves search, fill and find.
// ----------------------------------------------------------------------------
// One item is handled at a time. A search or a find reads the table one entry
// at a time through its single read port, each read followed by an evaluation
// state; a fill scans back for the last live entry and shifts entries up before
// it writes. A new item is taken as soon as the previous result is stored in
// the output register. Writing pool_size resets the table at once.
module best_fit_slot_allocator_unit import bfsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       op,
  input  logic [31:0]      request_size,
  input  logic [31:0]      alignment,
  input  logic [31:0]      type_mask,
  input  logic [IDX_W-1:0] slot_select,
  input  logic [31:0]      find_offset,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [IDX_W-1:0] slot_index,
  output logic [31:0]      size_needed,
  output logic [31:0]      slot_offset
);

  cmd_t  cmd;
  stat_t st;

  bfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bfsa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .request_size (request_size),
    .alignment    (alignment),
    .type_mask    (type_mask),
    .slot_select  (slot_select),
    .find_offset  (find_offset),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .slot_index   (slot_index),
    .size_needed  (size_needed),
    .slot_offset  (slot_offset),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

>>> rtl/core/bfsa_ctrl.sv
// ----------------------------------------------------------------------------
// Best-fit slot allocator controller
// Sequences search, fill and find requests over the slot table.
// ----------------------------------------------------------------------------
module bfsa_ctrl import bfsa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SEV   = 4'd3;
  localparam logic [3:0] S_DRD   = 4'd4;
  localparam logic [3:0] S_DEV   = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_KRD   = 4'd8;
  localparam logic [3:0] S_KEV   = 4'd9;
  localparam logic [3:0] S_KDONE = 4'd10;
  localparam logic [3:0] S_MRD   = 4'd11;
  localparam logic [3:0] S_MWR   = 4'd12;
  localparam logic [3:0] S_WR1   = 4'd13;
  localparam logic [3:0] S_WR0   = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (st.op == OP_SEARCH) begin
          if (st.bad_search) begin
            cmd.res = RES_NOFIT;
            state_next = S_FIN;
          end else begin
            cmd.idx_op = IDX_ZERO;
            cmd.best_clr = 1'b1;
            state_next = S_SRD;
          end
        end else if (st.op == OP_FILL) begin
          if (st.sel_bad) begin
            cmd.res = RES_BAD;
            state_next = S_FIN;
          end else begin
            cmd.idx_op = IDX_SEL;
            state_next = S_FRD;
          end
        end else if (st.op == OP_FIND) begin
          cmd.idx_op = IDX_ZERO;
          state_next = S_DRD;
        end else begin
          cmd.res = RES_NOFIT;
          state_next = S_FIN;
        end
      end
      S_SRD: begin
        if (st.idx_end) begin
          cmd.res = RES_SEARCH;
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_SEV;
        end
      end
      S_SEV: begin
        cmd.eval = 1'b1;
        cmd.idx_op = IDX_INC;
        state_next = S_SRD;
      end
      S_DRD: begin
        if (st.idx_end) begin
          cmd.res = RES_NOFIT;
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_DEV;
        end
      end
      S_DEV: begin
        if (st.find_hit) begin
          cmd.res = RES_FIND;
          state_next = S_FIN;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_DRD;
        end
      end
      S_FRD: begin
        cmd.rd = 1'b1;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        cmd.save = 1'b1;
        priority if (st.fill_bad) begin
          cmd.res = RES_BAD;
          state_next = S_FIN;
        end else if (st.fill_exact) begin
          state_next = S_WR0;
        end else begin
          cmd.idx_op = IDX_LAST;
          state_next = S_KRD;
        end
      end
      S_KRD: begin
        if (st.k_low) begin
          cmd.k_self = 1'b1;
          state_next = S_KDONE;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_KEV;
        end
      end
      S_KEV: begin
        if (st.k_hit) begin
          cmd.k_rd = 1'b1;
          state_next = S_KDONE;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_next = S_KRD;
        end
      end
      S_KDONE: begin
        if (st.k_tail && st.full) begin
          cmd.res = RES_FULL;
          state_next = S_FIN;
        end else begin
          cmd.cnt_inc = st.k_tail;
          cmd.idx_op = IDX_KNEXT;
          state_next = S_MRD;
        end
      end
      S_MRD: begin
        if (st.m_done) begin
          state_next = S_WR1;
        end else begin
          cmd.rd = 1'b1;
          cmd.rd_prev = 1'b1;
          state_next = S_MWR;
        end
      end
      S_MWR: begin
        cmd.wr = WR_SHIFT;
        cmd.idx_op = IDX_DEC;
        state_next = S_MRD;
      end
      S_WR1: begin
        cmd.wr = WR_REM;
        state_next = S_WR0;
      end
      S_WR0: begin
        cmd.wr = WR_FILL;
        cmd.res = RES_FILL;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/bfsa_dp.sv
// ----------------------------------------------------------------------------
// Best-fit slot allocator datapath
// Holds the slot table, the pool registers, the request and the result.
// ----------------------------------------------------------------------------
module bfsa_dp import bfsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [1:0]           op,
  input  logic [31:0]          request_size,
  input  logic [31:0]          alignment,
  input  logic [31:0]          type_mask,
  input  logic [IDX_W-1:0]     slot_select,
  input  logic [31:0]          find_offset,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           status,
  output logic [IDX_W-1:0]     slot_index,
  output logic [31:0]          size_needed,
  output logic [31:0]          slot_offset,
  input  cmd_t                 cmd,
  output stat_t                st
);

  logic [ADDR_BITS-1:0] pool_size;
  logic [4:0]           pool_type;
  logic [CNT_W-1:0]     slot_count;
  logic [MAX_SLOTS-1:0] vld;
  logic [ENTRY_W-1:0]   mem [MAX_SLOTS];
  logic [ENTRY_W-1:0]   rd_data;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_addr;

  logic [1:0]           r_op;
  logic [31:0]          r_size;
  logic [31:0]          r_align;
  logic [31:0]          r_mask;
  logic [IDX_W-1:0]     r_sel;
  logic [31:0]          r_off;

  logic [CNT_W-1:0]     idx;
  logic [IDX_W-1:0]     k;
  logic                 found;
  logic [31:0]          best_len;
  logic [31:0]          best_need;
  logic [IDX_W-1:0]     best_idx;
  logic [31:0]          best_start;
  logic [31:0]          sv_start;
  logic [31:0]          sv_len;

  logic [1:0]           res_status;
  logic [IDX_W-1:0]     res_index;
  logic [31:0]          res_need;
  logic [31:0]          res_off;

  logic                 e_used;
  logic [31:0]          e_start;
  logic [31:0]          e_len;
  logic [31:0]          pad;
  logic [32:0]          need;
  logic                 fit;
  logic [IDX_W-1:0]     rd_sel;
  logic [IDX_W-1:0]     sel_next;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]   wr_data;

  always_comb begin
    if (rd_vld) begin
      e_used  = rd_data[ENTRY_W-1];
      e_start = rd_data[2*ADDR_BITS-1:ADDR_BITS];
      e_len   = rd_data[ADDR_BITS-1:0];
    end else begin
      e_used  = 1'b0;
      e_start = (rd_addr == '0) ? '0 : pool_size;
      e_len   = (rd_addr == '0) ? pool_size : '0;
    end
  end

  assign pad      = (32'd0 - e_start) & (r_align - 32'd1);
  assign need     = {1'b0, r_size} + {1'b0, pad};
  assign fit      = !e_used && (need <= {1'b0, e_len}) && (!found || e_len < best_len);
  assign rd_sel   = cmd.rd_prev ? (idx[IDX_W-1:0] - IDX_W'(1)) : idx[IDX_W-1:0];
  assign sel_next = r_sel + IDX_W'(1);

  always_comb begin
    wr_addr = idx[IDX_W-1:0];
    wr_data = rd_data;
    unique case (cmd.wr)
      WR_SHIFT: begin
        wr_addr = idx[IDX_W-1:0];
        wr_data = {e_used, e_start, e_len};
      end
      WR_REM: begin
        wr_addr = sel_next;
        wr_data = {1'b0, sv_start + r_size, sv_len - r_size};
      end
      WR_FILL: begin
        wr_addr = r_sel;
        wr_data = {1'b1, sv_start, r_size};
      end
      default: begin
        wr_addr = idx[IDX_W-1:0];
        wr_data = rd_data;
      end
    endcase
  end

  always_comb begin
    st.op         = r_op;
    st.bad_search = (r_mask[pool_type] == 1'b0) || (r_size > pool_size) ||
                    (r_align == '0) || ((r_align & (r_align - 32'd1)) != '0);
    st.idx_end    = (idx >= slot_count);
    st.sel_bad    = ({1'b0, r_sel} >= slot_count);
    st.fill_bad   = e_used || (r_size > e_len);
    st.fill_exact = (r_size == e_len);
    st.k_low      = (idx <= {1'b0, r_sel});
    st.k_hit      = e_used || (e_len != '0);
    st.k_tail     = ({1'b0, k} + CNT_W'(1) >= slot_count);
    st.full       = (slot_count >= CNT_W'(MAX_SLOTS));
    st.m_done     = (idx <= {1'b0, r_sel} + CNT_W'(1));
    st.find_hit   = (e_start == r_off);
    st.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_sel];
    end
    if (cmd.wr != WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size  <= ADDR_BITS'(32'd16777216);
      pool_type  <= '0;
      slot_count <= CNT_W'(INIT_SLOTS);
      vld        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == 1'b0) begin
          pool_size  <= cfg_data;
          slot_count <= CNT_W'(INIT_SLOTS);
          vld        <= '0;
        end else begin
          pool_type <= cfg_data[4:0];
        end
      end else begin
        if (cmd.cnt_inc) begin
          slot_count <= slot_count + CNT_W'(1);
        end
        if (cmd.wr != WR_NONE) begin
          vld[wr_addr] <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_vld  <= vld[rd_sel];
      rd_addr <= rd_sel;
    end
    if (cmd.load) begin
      r_op    <= op;
      r_size  <= request_size;
      r_align <= alignment;
      r_mask  <= type_mask;
      r_sel   <= slot_select;
      r_off   <= find_offset;
    end
    unique case (cmd.idx_op)
      IDX_ZERO:  idx <= '0;
      IDX_INC:   idx <= idx + CNT_W'(1);
      IDX_DEC:   idx <= idx - CNT_W'(1);
      IDX_SEL:   idx <= {1'b0, r_sel};
      IDX_LAST:  idx <= slot_count - CNT_W'(1);
      IDX_KNEXT: idx <= {1'b0, k} + CNT_W'(1);
      default:   idx <= idx;
    endcase
    if (cmd.best_clr) begin
      found <= 1'b0;
    end else if (cmd.eval && fit) begin
      found      <= 1'b1;
      best_len   <= e_len;
      best_need  <= need[31:0];
      best_idx   <= rd_addr;
      best_start <= e_start;
    end
    if (cmd.save) begin
      sv_start <= e_start;
      sv_len   <= e_len;
    end
    if (cmd.k_self) begin
      k <= r_sel;
    end else if (cmd.k_rd) begin
      k <= rd_addr;
    end
    unique case (cmd.res)
      RES_NOFIT, RES_FULL, RES_BAD: begin
        res_status <= (cmd.res == RES_NOFIT) ? ST_NO_FIT :
                      (cmd.res == RES_FULL) ? ST_FULL : ST_BAD_FILL;
        res_index  <= '0;
        res_need   <= '0;
        res_off    <= '0;
      end
      RES_SEARCH: begin
        res_status <= found ? ST_OK : ST_NO_FIT;
        res_index  <= found ? best_idx : '0;
        res_need   <= found ? best_need : '0;
        res_off    <= found ? best_start : '0;
      end
      RES_FIND: begin
        res_status <= ST_OK;
        res_index  <= rd_addr;
        res_need   <= '0;
        res_off    <= e_start;
      end
      RES_FILL: begin
        res_status <= ST_OK;
        res_index  <= r_sel;
        res_need   <= r_size;
        res_off    <= sv_start;
      end
      default: begin
        res_status <= res_status;
      end
    endcase
    if (cmd.out_load) begin
      status      <= res_status;
      slot_index  <= res_index;
      size_needed <= res_need;
      slot_offset <= res_off;
    end
  end

endmodule
